// ===== design/lpp_pkg.sv =====
// Shared types and constants for the length-prefixed pair parser.
// No dependencies; the top level, the parser and the queue use this package.
package lpp_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int LEN_FIELD_BYTES = 8;
    localparam int ID_FIELD_BYTES  = 4;
    localparam int RES_QUEUE_DEPTH = 4;

    // Result kinds.
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_VALUE  = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // Error codes.
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_SHORT   = 2'd1;
    localparam logic [1:0] ERR_LONG    = 2'd2;
    localparam logic [1:0] ERR_OVERRUN = 2'd3;

    typedef enum logic [6:0] {
        PH_LEN   = 7'b0000001,
        PH_ID    = 7'b0000010,
        PH_VALUE = 7'b0000100,
        PH_SKIP  = 7'b0001000,
        PH_ERR1  = 7'b0010000,
        PH_ERR2  = 7'b0100000,
        PH_ERR3  = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] pair_id;
        logic [30:0] value_length;
        logic [7:0]  value_byte;
        logic [30:0] byte_index;
        logic        last_of_value;
        logic [1:0]  error_code;
        logic        last;
    } result_t;

    // Up to two results written into the queue in one cycle.
    typedef struct packed {
        logic [1:0] num;
        result_t    res0;
        result_t    res1;
    } push_t;

endpackage

// ===== design/lpp_byte_if.sv =====
// Input channel of the pair parser: one region byte per item.
// Depends on nothing.
interface lpp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

// ===== design/lpp_result_if.sv =====
// Output channel of the pair parser: one result per item.
// Depends on nothing.
interface lpp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] pair_id;
    logic [30:0] value_length;
    logic [7:0]  value_byte;
    logic [30:0] byte_index;
    logic        last_of_value;
    logic [1:0]  error_code;
    logic        last;

    modport source (output valid, output kind, output pair_id, output value_length,
                    output value_byte, output byte_index, output last_of_value,
                    output error_code, output last, input ready);
    modport sink (input valid, input kind, input pair_id, input value_length,
                  input value_byte, input byte_index, input last_of_value,
                  input error_code, input last, output ready);
endinterface

// ===== design/length_prefixed_pair_parser_top.sv =====
// Top level of the length-prefixed pair parser: channels, register port, parser and queue.
// Depends on lpp_pkg, lpp_byte_if, lpp_result_if, lpp_parser and lpp_res_queue.
//
// The block takes one region byte per clock cycle while the result queue has room and registers
// its results in that queue. A byte gives no result, one result, or two when it is the last byte
// of the region and also carries a header or value byte; the output hands over one result per
// cycle while results.ready is high. Bytes are accepted while the four-entry result queue has
// room for two more results, which does not depend on the output side in the same cycle. Writing
// the region length restarts the parse at the start of a region; the user does so only while
// the block is idle (not enforced by the block); after reset the region length is zero and every byte is dropped.
module length_prefixed_pair_parser_top #(
    parameter int OFFSET_BITS = lpp_pkg::OFFSET_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    lpp_byte_if.sink            bytes,
    lpp_result_if.source        results,
    input  logic                cfg_wr_en,
    input  logic [31:0]         cfg_wr_data
);

    lpp_pkg::push_t   push;
    lpp_pkg::result_t head;
    logic             has_room;
    logic             not_empty;
    logic             accept;

    assign bytes.ready = has_room;
    assign accept      = bytes.valid && has_room;

    lpp_parser #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (bytes.data_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push)
    );

    lpp_res_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (results.ready),
        .head      (head),
        .not_empty (not_empty),
        .has_room  (has_room)
    );

    assign results.valid         = not_empty;
    assign results.kind          = head.kind;
    assign results.pair_id       = head.pair_id;
    assign results.value_length  = head.value_length;
    assign results.value_byte    = head.value_byte;
    assign results.byte_index    = head.byte_index;
    assign results.last_of_value = head.last_of_value;
    assign results.error_code    = head.error_code;
    assign results.last          = head.last;

endmodule

// ===== design/lpp_parser.sv =====
// Parse state machine: takes one byte per accepted item and produces up to two results.
// Depends on lpp_pkg.
module lpp_parser #(
    parameter int OFFSET_BITS = lpp_pkg::OFFSET_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    input  logic                  cfg_wr_en,
    input  logic [31:0]           cfg_wr_data,
    output lpp_pkg::push_t        push
);

    localparam logic [63:0] OFFSET_MAX = (64'd1 << OFFSET_BITS) - 64'd1;

    lpp_pkg::phase_t phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] region_reg, region_next;
    logic [OFFSET_BITS-1:0] rem_reg, rem_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [63:0] len_reg, len_next;
    logic [31:0] id_reg, id_next;
    logic [30:0] vlen_reg, vlen_next;
    logic [30:0] vrem_reg, vrem_next;
    logic [30:0] idx_reg, idx_next;

    logic [63:0]            len_full;
    logic [31:0]            id_full;
    logic [63:0]            cfg_ext;
    logic [OFFSET_BITS-1:0] cfg_eff;
    lpp_pkg::result_t       res_a, res_fin;
    logic                   have_a, have_fin;

    assign len_full = {data_byte, len_reg[55:0]};
    assign id_full  = {data_byte, id_reg[23:0]};
    assign cfg_ext  = {32'd0, cfg_wr_data};
    assign cfg_eff  = (cfg_ext > OFFSET_MAX) ? '1 : cfg_ext[OFFSET_BITS-1:0];

    always_comb
    begin
        phase_next  = phase_reg;
        region_next = region_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        len_next    = len_reg;
        id_next     = id_reg;
        vlen_next   = vlen_reg;
        vrem_next   = vrem_reg;
        idx_next    = idx_reg;
        res_a       = '0;
        res_fin     = '0;
        have_a      = 1'b0;
        have_fin    = 1'b0;
        push        = '0;

        if (accept && rem_reg != '0)
        begin
            unique case (phase_reg)
                lpp_pkg::PH_LEN:
                begin
                    if (cnt_reg == 3'd0 &&
                        rem_reg < OFFSET_BITS'(lpp_pkg::LEN_FIELD_BYTES))
                    begin
                        phase_next = lpp_pkg::PH_SKIP;
                    end
                    else if (cnt_reg == 3'(lpp_pkg::LEN_FIELD_BYTES - 1))
                    begin
                        len_next  = len_full;
                        cnt_next  = 3'd0;
                        vlen_next = len_full[30:0] - 31'(lpp_pkg::ID_FIELD_BYTES);
                        // The bytes left after this one are rem_reg - 1.
                        if (len_full < 64'(lpp_pkg::ID_FIELD_BYTES))
                            phase_next = lpp_pkg::PH_ERR1;
                        else if (|len_full[63:31])
                            phase_next = lpp_pkg::PH_ERR2;
                        else if (len_full >= 64'(rem_reg))
                            phase_next = lpp_pkg::PH_ERR3;
                        else
                            phase_next = lpp_pkg::PH_ID;
                    end
                    else
                    begin
                        len_next[{cnt_reg, 3'b000} +: 8] = data_byte;
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                lpp_pkg::PH_ID:
                begin
                    if (cnt_reg == 3'(lpp_pkg::ID_FIELD_BYTES - 1))
                    begin
                        cnt_next           = 3'd0;
                        id_next            = id_full;
                        have_a             = 1'b1;
                        res_a.kind         = lpp_pkg::KIND_HEADER;
                        res_a.pair_id      = id_full;
                        res_a.value_length = vlen_reg;
                        if (vlen_reg == 31'd0)
                        begin
                            phase_next = lpp_pkg::PH_LEN;
                            len_next   = '0;
                        end
                        else
                        begin
                            phase_next = lpp_pkg::PH_VALUE;
                            vrem_next  = vlen_reg;
                            idx_next   = 31'd0;
                        end
                    end
                    else
                    begin
                        id_next[{cnt_reg[1:0], 3'b000} +: 8] = data_byte;
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                lpp_pkg::PH_VALUE:
                begin
                    have_a              = 1'b1;
                    res_a.kind          = lpp_pkg::KIND_VALUE;
                    res_a.pair_id       = id_reg;
                    res_a.value_length  = vlen_reg;
                    res_a.value_byte    = data_byte;
                    res_a.byte_index    = idx_reg;
                    res_a.last_of_value = (vrem_reg == 31'd1);
                    vrem_next           = vrem_reg - 31'd1;
                    idx_next            = idx_reg + 31'd1;
                    if (vrem_reg == 31'd1)
                    begin
                        phase_next = lpp_pkg::PH_LEN;
                        len_next   = '0;
                        cnt_next   = 3'd0;
                    end
                end
                default:
                begin
                end
            endcase

            if (rem_reg == OFFSET_BITS'(1))
            begin
                have_fin = 1'b1;
                unique case (phase_next)
                    lpp_pkg::PH_ERR1:
                    begin
                        res_fin.kind       = lpp_pkg::KIND_ERROR;
                        res_fin.error_code = lpp_pkg::ERR_SHORT;
                    end
                    lpp_pkg::PH_ERR2:
                    begin
                        res_fin.kind       = lpp_pkg::KIND_ERROR;
                        res_fin.error_code = lpp_pkg::ERR_LONG;
                    end
                    lpp_pkg::PH_ERR3:
                    begin
                        res_fin.kind       = lpp_pkg::KIND_ERROR;
                        res_fin.error_code = lpp_pkg::ERR_OVERRUN;
                    end
                    default:
                    begin
                        res_fin.kind       = lpp_pkg::KIND_DONE;
                        res_fin.error_code = lpp_pkg::ERR_NONE;
                    end
                endcase
                res_fin.last = 1'b1;
                // The region ends here: start over on a region of the same length.
                phase_next = lpp_pkg::PH_LEN;
                rem_next   = region_reg;
                cnt_next   = 3'd0;
                len_next   = '0;
                id_next    = '0;
                vrem_next  = '0;
            end
            else
            begin
                rem_next = rem_reg - OFFSET_BITS'(1);
            end

            if (have_a && have_fin)
            begin
                push.num  = 2'd2;
                push.res0 = res_a;
                push.res1 = res_fin;
            end
            else if (have_a)
            begin
                push.num       = 2'd1;
                push.res0      = res_a;
                push.res0.last = 1'b1;
            end
            else if (have_fin)
            begin
                push.num  = 2'd1;
                push.res0 = res_fin;
            end
        end

        if (cfg_wr_en)
        begin
            region_next = cfg_eff;
            rem_next    = cfg_eff;
            phase_next  = lpp_pkg::PH_LEN;
            cnt_next    = 3'd0;
            len_next    = '0;
            id_next     = '0;
            vrem_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= lpp_pkg::PH_LEN;
            region_reg <= '0;
            rem_reg    <= '0;
            cnt_reg    <= '0;
            len_reg    <= '0;
            id_reg     <= '0;
            vlen_reg   <= '0;
            vrem_reg   <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            region_reg <= region_next;
            rem_reg    <= rem_next;
            cnt_reg    <= cnt_next;
            len_reg    <= len_next;
            id_reg     <= id_next;
            vlen_reg   <= vlen_next;
            vrem_reg   <= vrem_next;
            idx_reg    <= idx_next;
        end
    end

    // A byte that gives two results always closes its region.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.num == 2'd2) |->
        (push.res1.kind == lpp_pkg::KIND_DONE || push.res1.kind == lpp_pkg::KIND_ERROR))
        else $error("second result of a byte is not a region end");

    // While value bytes are expected the countdown has not run out.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == lpp_pkg::PH_VALUE) |-> (vrem_reg != 31'd0))
        else $error("value phase with no bytes remaining");

    // The bytes left never exceed the region length.
    assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= region_reg)
        else $error("remaining count beyond region length");

    // With no region left, an accepted byte gives nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && rem_reg == '0) |-> (push.num == 2'd0))
        else $error("result produced outside the region");

endmodule

// ===== design/lpp_res_queue.sv =====
// Small result queue: takes up to two results a cycle, hands out one.
// Depends on lpp_pkg.
module lpp_res_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  lpp_pkg::push_t   push,
    input  logic             pop,
    output lpp_pkg::result_t head,
    output logic             not_empty,
    output logic             has_room
);

    localparam int DEPTH = lpp_pkg::RES_QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    lpp_pkg::result_t  slot_reg [DEPTH];
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_pop;

    assign not_empty = (count_reg != '0);
    // Room for the two results that one byte can give.
    assign has_room  = (count_reg <= CNT_W'(DEPTH - 2));
    assign head      = slot_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.num);
        count_next  = count_reg + CNT_W'(push.num) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
            slot_reg[wr_ptr_reg] <= push.res0;
        if (push.num == 2'd2)
            slot_reg[wr_ptr_reg + PTR_W'(1)] <= push.res1;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue overfilled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push.num != 2'd0) |-> has_room)
        else $error("results written without room");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule
